// File: design/hed_pkg.sv
package hed_pkg;

  localparam int ROM_SIZE  = 257;
  localparam int ROM_CHARS = 8;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [1:0] FORM_NAMED = 2'd0;
  localparam logic [1:0] FORM_DEC   = 2'd1;
  localparam logic [1:0] FORM_HEX   = 2'd2;

  typedef logic [8*ROM_CHARS-1:0] name_t;

  typedef struct packed {
    name_t       nm;
    logic [31:0] cp;
  } rom_entry_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] cp;
    logic        tolerated;
  } match_t;

  localparam name_t TOL_NAMES [5] = '{"lt", "gt", "amp", "quot", "nbsp"};

  localparam rom_entry_t ROM [ROM_SIZE] = '{
    '{"otimes",32'h2297},'{"laquo",32'hAB},'{"cap",32'h2229},'{"dArr",32'h21D3},
    '{"euml",32'hEB},'{"sum",32'h2211},'{"Ocirc",32'hD4},'{"dagger",32'h2020},
    '{"Scaron",32'h0160},'{"Omicron",32'h039F},'{"brvbar",32'hA6},'{"Eta",32'h0397},
    '{"iacute",32'hED},'{"aelig",32'hE6},'{"Ugrave",32'hD9},'{"deg",32'hB0},
    '{"Yuml",32'h0178},'{"sup",32'h2283},'{"middot",32'hB7},'{"ge",32'h2265},
    '{"alefsym",32'h2135},'{"sigma",32'h03C3},'{"aring",32'hE5},'{"Icirc",32'hCE},
    '{"and",32'h2227},'{"weierp",32'h2118},'{"frac12",32'hBD},'{"radic",32'h221A},
    '{"chi",32'h03C7},'{"zeta",32'h03B6},'{"Theta",32'h0398},'{"Atilde",32'hC3},
    '{"para",32'hB6},'{"frac14",32'hBC},'{"cedil",32'hB8},'{"quot",32'h22},
    '{"ang",32'h2220},'{"ucirc",32'hFB},'{"supe",32'h2287},'{"iota",32'h03B9},
    '{"Ograve",32'hD2},'{"rArr",32'h21D2},'{"Auml",32'hC4},'{"frac34",32'hBE},
    '{"nbsp",32'hA0},'{"euro",32'h20AC},'{"ocirc",32'hF4},'{"equiv",32'h2261},
    '{"upsilon",32'h03C5},'{"sigmaf",32'h03C2},'{"ETH",32'hD0},'{"le",32'h2264},
    '{"beta",32'h03B2},'{"yacute",32'hFD},'{"egrave",32'hE8},'{"lowast",32'h2217},
    '{"real",32'h211C},'{"amp",32'h26},'{"icirc",32'hEE},'{"micro",32'hB5},
    '{"isin",32'h2208},'{"curren",32'hA4},'{"rdquo",32'h201D},'{"sbquo",32'h201A},
    '{"ne",32'h2260},'{"theta",32'h03B8},'{"Igrave",32'hCC},'{"gt",32'h3E},
    '{"hearts",32'h2665},'{"rang",32'h232A},'{"rfloor",32'h230B},'{"ldquo",32'h201C},
    '{"ni",32'h220B},'{"Ntilde",32'hD1},'{"Aacute",32'hC1},'{"crarr",32'h21B5},
    '{"Ouml",32'hD6},'{"GT",32'h3E},'{"clubs",32'h2663},'{"scaron",32'h0161},
    '{"part",32'h2202},'{"tilde",32'h02DC},'{"oelig",32'h0153},'{"pi",32'h03C0},
    '{"ugrave",32'hF9},'{"darr",32'h2193},'{"uuml",32'hFC},'{"QUOT",32'h22},
    '{"Prime",32'h2033},'{"zwj",32'h200D},'{"lfloor",32'h230A},'{"notin",32'h2209},
    '{"cent",32'hA2},'{"lt",32'h3C},'{"eta",32'h03B7},'{"Phi",32'h03A6},
    '{"atilde",32'hE3},'{"hArr",32'h21D4},'{"iuml",32'hEF},'{"NBSP",32'hA0},
    '{"mu",32'h03BC},'{"or",32'h2228},'{"plusmn",32'hB1},'{"LT",32'h3C},
    '{"nu",32'h03BD},'{"ograve",32'hF2},'{"AElig",32'hC6},'{"rceil",32'h2309},
    '{"uArr",32'h21D1},'{"sect",32'hA7},'{"circ",32'h02C6},'{"perp",32'h22A5},
    '{"eth",32'hF0},'{"rsquo",32'h2019},'{"nabla",32'h2207},'{"lceil",32'h2308},
    '{"cup",32'h222A},'{"exist",32'h2203},'{"rarr",32'h2192},'{"upsih",32'h03D2},
    '{"prime",32'h2032},'{"Omega",32'h03A9},'{"Ecirc",32'hCA},'{"Epsilon",32'h0395},
    '{"lsquo",32'h2018},'{"xi",32'h03BE},'{"Lambda",32'h039B},'{"Kappa",32'h039A},
    '{"divide",32'hF7},'{"igrave",32'hEC},'{"acute",32'hB4},'{"Euml",32'hCB},
    '{"ordf",32'hAA},'{"image",32'h2111},'{"Tau",32'h03A4},'{"Rho",32'h03A1},
    '{"ntilde",32'hF1},'{"aacute",32'hE1},'{"times",32'hD7},'{"omicron",32'h03BF},
    '{"oplus",32'h2295},'{"Zeta",32'h0396},'{"Eacute",32'hC9},'{"ordm",32'hBA},
    '{"Oslash",32'hD8},'{"Ccedil",32'hC7},'{"iquest",32'hBF},'{"omega",32'h03C9},
    '{"Psi",32'h03A8},'{"ecirc",32'hEA},'{"int",32'h222B},'{"trade",32'h2122},
    '{"kappa",32'h03BA},'{"Iota",32'h0399},'{"Delta",32'h0394},'{"Alpha",32'h0391},
    '{"Otilde",32'hD5},'{"sdot",32'h22C5},'{"cong",32'h2245},'{"rsaquo",32'h203A},
    '{"OElig",32'h0152},'{"diams",32'h2666},'{"phi",32'h03C6},'{"Beta",32'h0392},
    '{"szlig",32'hDF},'{"sup1",32'hB9},'{"reg",32'hAE},'{"harr",32'h2194},
    '{"hellip",32'h2026},'{"yuml",32'hFF},'{"sup2",32'hB2},'{"Gamma",32'h0393},
    '{"sup3",32'hB3},'{"forall",32'h2200},'{"bdquo",32'h201E},'{"spades",32'h2660},
    '{"Pi",32'h03A0},'{"Uacute",32'hDA},'{"Agrave",32'hC0},'{"permil",32'h2030},
    '{"mdash",32'h2014},'{"lArr",32'h21D0},'{"uarr",32'h2191},'{"Upsilon",32'h03A5},
    '{"pound",32'hA3},'{"lsaquo",32'h2039},'{"lrm",32'h200E},'{"lambda",32'h03BB},
    '{"delta",32'h03B4},'{"alpha",32'h03B1},'{"frasl",32'h2044},'{"thorn",32'hFE},
    '{"auml",32'hE4},'{"Mu",32'h039C},'{"nsub",32'h2284},'{"macr",32'hAF},
    '{"minus",32'h2212},'{"Nu",32'h039D},'{"Oacute",32'hD3},'{"prod",32'h220F},
    '{"Uuml",32'hDC},'{"iexcl",32'hA1},'{"lang",32'h2329},'{"tau",32'h03C4},
    '{"rho",32'h03C1},'{"gamma",32'h03B3},'{"loz",32'h25CA},'{"bull",32'h2022},
    '{"piv",32'h03D6},'{"eacute",32'hE9},'{"zwnj",32'h200C},'{"oslash",32'hF8},
    '{"ccedil",32'hE7},'{"THORN",32'hDE},'{"Iuml",32'hCF},'{"not",32'hAC},
    '{"sim",32'h223C},'{"thetasym",32'h03D1},'{"Acirc",32'hC2},'{"Dagger",32'h2021},
    '{"fnof",32'h0192},'{"rlm",32'h200F},'{"oline",32'h203E},'{"Chi",32'h03A7},
    '{"Xi",32'h039E},'{"otilde",32'hF5},'{"Iacute",32'hCD},'{"copy",32'hA9},
    '{"ndash",32'h2013},'{"ouml",32'hF6},'{"psi",32'h03C8},'{"sube",32'h2286},
    '{"emsp",32'h2003},'{"asymp",32'h2248},'{"prop",32'h221D},'{"infin",32'h221E},
    '{"empty",32'h2205},'{"uacute",32'hFA},'{"agrave",32'hE0},'{"shy",32'hAD},
    '{"ensp",32'h2002},'{"acirc",32'hE2},'{"sub",32'h2282},'{"epsilon",32'h03B5},
    '{"Yacute",32'hDD},'{"Egrave",32'hC8},'{"there4",32'h2234},'{"larr",32'h2190},
    '{"uml",32'hA8},'{"AMP",32'h26},'{"Sigma",32'h03A3},'{"Aring",32'hC5},
    '{"yen",32'hA5},'{"oacute",32'hF3},'{"raquo",32'hBB},'{"thinsp",32'h2009},
    '{"Ucirc",32'hDB}
  };

endpackage

// File: design/hed_match.sv
module hed_match (
  input  hed_pkg::name_t  name,
  input  logic            valid_len,
  output hed_pkg::match_t result
);
  import hed_pkg::*;

  // Each name is right-justified and zero-padded, like a string literal.
  name_t lname;

  always_comb begin
    for (int k = 0; k < ROM_CHARS; k++) begin
      lname[8*k +: 8] = name[8*k +: 8];
      if (name[8*k +: 8] >= 8'h41 && name[8*k +: 8] <= 8'h5A) begin
        lname[8*k +: 8] = name[8*k +: 8] + 8'd32;
      end
    end
  end

  always_comb begin
    result = '0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (valid_len && name == ROM[i].nm) begin
        result.hit = 1'b1;
        result.cp  = result.cp | ROM[i].cp;
      end
    end
    for (int t = 0; t < 5; t++) begin
      if (valid_len && lname == TOL_NAMES[t]) begin
        result.tolerated = 1'b1;
      end
    end
  end

endmodule

// File: design/html_entity_decoder_core.sv
// Pipeline: an accepted word is first registered in the input stage and then decoded
// into the output register, where its result word is held until it is taken.
// Throughput: one input word per cycle while the output is not stalled, with no bubbles between references.
// Words that continue a reference produce no result word; the terminating word does.
// Reset: synchronous, active low; clears the input and output stages and sets the
// decoder to idle, so bytes without a begin flag are ignored until a new attempt.
module html_entity_decoder_core #(
  parameter int MAX_NAME_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_begin_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic        out_found,
  output logic [7:0]  out_consumed,
  output logic [1:0]  out_form
);
  import hed_pkg::*;

  localparam int LW = $clog2(MAX_NAME_LEN + 1);

  // Decoder phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_AMP      = 3'd1;
  localparam logic [2:0] PH_SHARP    = 3'd2;
  localparam logic [2:0] PH_HEXFIRST = 3'd3;
  localparam logic [2:0] PH_DEC      = 3'd4;
  localparam logic [2:0] PH_HEX      = 3'd5;
  localparam logic [2:0] PH_NAME     = 3'd6;

  // Input stage: the word is registered before it is decoded.
  logic       s_valid_r;
  logic [7:0] s_byte_r;
  logic       s_begin_r;

  // Decoder state, updated as the registered word is consumed.
  logic [2:0]    phase_r, phase_nxt;
  logic [31:0]   acc_r, acc_nxt;
  name_t         name_r, name_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovl_r, ovl_nxt;
  logic [7:0]    cnt_r, cnt_nxt;

  // Output register holding one result word until it is taken.
  logic        o_valid_r;
  logic [31:0] o_cp_r;
  logic        o_found_r;
  logic [7:0]  o_cnt_r;
  logic [1:0]  o_form_r;

  logic        emit;
  logic [31:0] e_cp;
  logic        e_found;
  logic [1:0]  e_form;
  logic        advance;
  match_t      m;

  // The decode stage moves whenever the output register is free or being emptied.
  assign advance  = !o_valid_r || !out_stall;
  assign in_stall = s_valid_r && !advance;

  // The name compare works on the characters gathered so far.
  hed_match u_match (
    .name      (name_r),
    .valid_len (!ovl_r && (len_r <= LW'(ROM_CHARS))),
    .result    (m)
  );

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_dec(c)) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  always_comb begin
    logic [2:0] ph;
    logic [7:0] c;
    logic [7:0] cnt_inc;
    c         = s_byte_r;
    ph        = s_begin_r ? PH_AMP : phase_r;
    phase_nxt = ph;
    acc_nxt   = s_begin_r ? '0 : acc_r;
    len_nxt   = s_begin_r ? '0 : len_r;
    ovl_nxt   = s_begin_r ? 1'b0 : ovl_r;
    cnt_nxt   = s_begin_r ? '0 : cnt_r;
    name_nxt  = name_r;
    emit      = 1'b0;
    e_cp      = '0;
    e_found   = 1'b0;
    e_form    = FORM_NAMED;
    // The count saturates at its top value.
    cnt_inc   = (cnt_nxt == 8'hFF) ? cnt_nxt : cnt_nxt + 8'd1;

    if (s_begin_r && c == CH_AMP) begin
      cnt_nxt   = 8'd1;
      phase_nxt = PH_AMP;
    end else begin
      unique case (ph)
        PH_AMP: begin
          if (c == CH_SHARP) begin
            cnt_nxt   = cnt_inc;
            phase_nxt = PH_SHARP;
          end else if (is_letter(c)) begin
            name_nxt  = name_t'(c);
            len_nxt   = LW'(1);
            cnt_nxt   = cnt_inc;
            phase_nxt = PH_NAME;
          end else begin
            emit = 1'b1;
          end
        end
        PH_SHARP: begin
          if (c == CH_LX || c == CH_UX) begin
            cnt_nxt   = cnt_inc;
            phase_nxt = PH_HEXFIRST;
          end else if (is_dec(c)) begin
            acc_nxt   = {28'd0, hex_val(c)};
            cnt_nxt   = cnt_inc;
            phase_nxt = PH_DEC;
          end else begin
            emit   = 1'b1;
            e_form = FORM_DEC;
          end
        end
        PH_HEXFIRST: begin
          if (is_hex(c)) begin
            acc_nxt   = {28'd0, hex_val(c)};
            cnt_nxt   = cnt_inc;
            phase_nxt = PH_HEX;
          end else begin
            emit   = 1'b1;
            e_form = FORM_HEX;
          end
        end
        PH_DEC: begin
          if (is_dec(c)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, hex_val(c)};
            cnt_nxt = cnt_inc;
          end else begin
            if (c == CH_SEMI) begin
              cnt_nxt = cnt_inc;
            end
            emit    = 1'b1;
            e_cp    = acc_r;
            e_found = 1'b1;
            e_form  = FORM_DEC;
          end
        end
        PH_HEX: begin
          if (is_hex(c)) begin
            acc_nxt = {acc_r[27:0], hex_val(c)};
            cnt_nxt = cnt_inc;
          end else begin
            if (c == CH_SEMI) begin
              cnt_nxt = cnt_inc;
            end
            emit    = 1'b1;
            e_cp    = acc_r;
            e_found = 1'b1;
            e_form  = FORM_HEX;
          end
        end
        PH_NAME: begin
          if (is_dec(c) || is_letter(c)) begin
            if (len_r < LW'(MAX_NAME_LEN)) begin
              name_nxt = {name_r[8*ROM_CHARS-9:0], c};
              len_nxt  = len_r + LW'(1);
            end else begin
              ovl_nxt = 1'b1;
            end
            cnt_nxt = cnt_inc;
          end else begin
            emit = 1'b1;
            if (c == CH_SEMI) begin
              cnt_nxt = cnt_inc;
              e_found = m.hit;
              e_cp    = m.hit ? m.cp : '0;
            end else if (c != CH_EQ && m.tolerated) begin
              e_found = m.hit;
              e_cp    = m.hit ? m.cp : '0;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      len_r     <= '0;
      ovl_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (!in_stall) begin
        s_valid_r <= in_valid;
      end
      if (advance) begin
        o_valid_r <= s_valid_r && emit;
        if (s_valid_r) begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          len_r   <= len_nxt;
          ovl_r   <= ovl_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s_byte_r  <= in_text_byte;
      s_begin_r <= in_begin_req;
    end
    if (advance && s_valid_r) begin
      name_r    <= name_nxt;
      o_cp_r    <= e_cp;
      o_found_r <= e_found;
      o_cnt_r   <= cnt_nxt;
      o_form_r  <= e_form;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_code_point = o_cp_r;
  assign out_found      = o_found_r;
  assign out_consumed   = o_cnt_r;
  assign out_form       = o_form_r;

endmodule

// File: design/hed_checker.sv
module hed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_code_point,
  input logic        out_found,
  input logic [7:0]  out_consumed,
  input logic [1:0]  out_form
);
  import hed_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point) && $stable(out_consumed))
    else $error("stalled result word changed");

  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_code_point == 32'd0)
    else $error("failed decode with non-zero code point");

  a_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_form == FORM_NAMED || out_form == FORM_DEC || out_form == FORM_HEX)
    else $error("illegal form");

  a_found_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_consumed != 8'd0)
    else $error("decoded reference consumed nothing");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code_point (out_code_point),
  .out_found      (out_found),
  .out_consumed   (out_consumed),
  .out_form       (out_form)
);

// File: sim/tb_html_entity_decoder_core.sv
// Testbench for the HTML character reference decoder.
// Bytes are driven on the input channel at the falling edge and both channels are sampled
// at the rising edge. Every accepted input word is fed to a predictor held in a small
// scoreboard class. Each result word is compared, field by field, with the oldest
// predicted result.
module tb_html_entity_decoder_core;
  import hed_pkg::*;

  localparam int NAME_MAX   = 8;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_BYTES = 200;

  typedef enum logic [2:0] {
    ST_IDLE, ST_AMP, ST_SHARP, ST_HEXFIRST, ST_DEC, ST_HEX, ST_NAME
  } dec_state_e;

  typedef struct packed {
    logic [31:0] cp;
    logic        found;
    logic [7:0]  consumed;
    logic [1:0]  form;
  } ref_result_t;

  // The scoreboard keeps its own copy of the decoder state and a queue of the result
  // words that the accepted bytes are expected to produce.
  class ref_scoreboard;
    dec_state_e  st;
    logic [31:0] acc;
    name_t       nm;
    int          nlen;
    bit          overlong;
    logic [7:0]  cnt;
    ref_result_t pending[$];
    int          errors;

    function new();
      st = ST_IDLE; acc = 0; nm = '0; nlen = 0; overlong = 0; cnt = 0; errors = 0;
    endfunction

    function bit is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_hex(logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [31:0] hex_digit(logic [7:0] c);
      if (is_dec(c)) return 32'(c - "0");
      if (c >= "a" && c <= "f") return 32'(c - "a" + 10);
      return 32'(c - "A" + 10);
    endfunction

    function void bump();
      if (cnt != 8'hFF) cnt++;
    endfunction

    function void push_result(logic [31:0] cp, bit ok, logic [1:0] form);
      ref_result_t r;
      r.cp = ok ? cp : 32'd0;
      r.found = ok;
      r.consumed = cnt;
      r.form = form;
      pending.push_back(r);
      st = ST_IDLE;
    endfunction

    // Only the five short names may stand without a semicolon, in any case.
    function bit short_form_ok();
      name_t low;
      low = nm;
      if (overlong) return 0;
      for (int i = 0; i < 8; i++)
        if (low[8*i +: 8] >= "A" && low[8*i +: 8] <= "Z") low[8*i +: 8] += 8'd32;
      foreach (TOL_NAMES[i]) if (TOL_NAMES[i] == low) return 1;
      return 0;
    endfunction

    function void note(logic [7:0] c, bit beg);
      bit hit;
      logic [31:0] cp;
      hit = 0;
      cp = 0;
      if (beg) begin
        cnt = 0; acc = 0; nlen = 0; overlong = 0; nm = '0;
        st = ST_AMP;
        if (c == CH_AMP) begin
          bump();
          return;
        end
      end
      case (st)
        ST_AMP: begin
          if (c == CH_SHARP) begin
            bump(); st = ST_SHARP;
          end else if (is_letter(c)) begin
            nm = {nm[8*ROM_CHARS-9:0], c}; nlen = 1; bump(); st = ST_NAME;
          end else begin
            push_result(0, 0, FORM_NAMED);
          end
        end
        ST_SHARP: begin
          if (c == CH_LX || c == CH_UX) begin
            bump(); st = ST_HEXFIRST;
          end else if (is_dec(c)) begin
            acc = 32'(c - "0"); bump(); st = ST_DEC;
          end else begin
            push_result(0, 0, FORM_DEC);
          end
        end
        ST_HEXFIRST: begin
          if (is_hex(c)) begin
            acc = hex_digit(c); bump(); st = ST_HEX;
          end else begin
            push_result(0, 0, FORM_HEX);
          end
        end
        ST_DEC: begin
          if (is_dec(c)) begin
            acc = acc * 10 + 32'(c - "0"); bump();
          end else begin
            if (c == CH_SEMI) bump();
            push_result(acc, 1, FORM_DEC);
          end
        end
        ST_HEX: begin
          if (is_hex(c)) begin
            acc = (acc << 4) + hex_digit(c); bump();
          end else begin
            if (c == CH_SEMI) bump();
            push_result(acc, 1, FORM_HEX);
          end
        end
        ST_NAME: begin
          if (is_dec(c) || is_letter(c)) begin
            if (nlen < NAME_MAX) begin
              nm = {nm[8*ROM_CHARS-9:0], c}; nlen++;
            end else begin
              overlong = 1;
            end
            bump();
          end else if (c != CH_SEMI && (c == CH_EQ || !short_form_ok())) begin
            push_result(0, 0, FORM_NAMED);
          end else begin
            if (c == CH_SEMI) bump();
            if (!overlong)
              foreach (ROM[i]) if (!hit && ROM[i].nm == nm) begin
                hit = 1; cp = ROM[i].cp;
              end
            push_result(cp, hit, FORM_NAMED);
          end
        end
        default: st = ST_IDLE;
      endcase
    endfunction

    function void check(ref_result_t got);
      ref_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word cp=%h found=%b consumed=%0d form=%0d",
                 $time, got.cp, got.found, got.consumed, got.form);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cp != want.cp) begin
        $display("%0t: code_point expected %h actual %h", $time, want.cp, got.cp);
        errors++;
      end
      if (got.found != want.found) begin
        $display("%0t: found expected %b actual %b", $time, want.found, got.found);
        errors++;
      end
      if (got.consumed != want.consumed) begin
        $display("%0t: consumed expected %0d actual %0d", $time, want.consumed, got.consumed);
        errors++;
      end
      if (got.form != want.form) begin
        $display("%0t: form expected %0d actual %0d", $time, want.form, got.form);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 0;
  logic        in_begin_req = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_code_point;
  logic        out_found;
  logic [7:0]  out_consumed;
  logic [1:0]  out_form;

  ref_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int sent      = 0;

  html_entity_decoder_core #(.MAX_NAME_LEN(NAME_MAX)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_text_byte(in_text_byte), .in_begin_req(in_begin_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_point(out_code_point), .out_found(out_found),
    .out_consumed(out_consumed), .out_form(out_form)
  );

  initial forever #4 clk = ~clk;

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Both channels are sampled at the rising edge; the testbench only drives at the falling
  // edge, so these reads see the values that the block itself saw.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) sb.note(in_text_byte, in_begin_req);
    if (rst_n && out_valid && !out_stall)
      sb.check('{cp: out_code_point, found: out_found, consumed: out_consumed,
                 form: out_form});
  end

  // Offers one word, with random idle cycles ahead of it, and holds it until it is taken.
  task automatic send_byte(logic [7:0] b, bit beg);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid     <= 1;
    in_text_byte <= b;
    in_begin_req <= beg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // The first character carries the begin flag; the rest continue the attempt.
  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_alnum();
    int k;
    k = $urandom_range(61);
    if (k < 10) return 8'("0" + k);
    if (k < 36) return 8'("a" + k - 10);
    return 8'("A" + k - 36);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ($urandom_range(1) == 0) return c;
    if (c >= "a" && c <= "z") return c - 8'd32;
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  // A terminator that is mostly a semicolon, sometimes any byte at all.
  function automatic logic [7:0] pick_end();
    if ($urandom_range(9) < 7) return CH_SEMI;
    return 8'($urandom_range(255));
  endfunction

  // Builds one random reference attempt, mostly well formed, and sends it.
  task automatic send_random_ref();
    logic [8:0] seq[$];
    int kind, n;
    name_t nmw;
    kind = $urandom_range(99);
    if ($urandom_range(3) != 0) seq.push_back({1'b1, CH_AMP});
    if (kind < 20) begin
      seq.push_back({1'b0, CH_SHARP});
      n = $urandom_range(12, 1);
      repeat (n) seq.push_back({1'b0, 8'("0" + $urandom_range(9))});
      seq.push_back({1'b0, pick_end()});
    end else if (kind < 35) begin
      seq.push_back({1'b0, CH_SHARP});
      seq.push_back({1'b0, $urandom_range(1) ? CH_LX : CH_UX});
      n = $urandom_range(10, 1);
      repeat (n) begin
        int d;
        d = $urandom_range(15);
        seq.push_back({1'b0, d < 10 ? 8'("0" + d) : flip_case(8'("a" + d - 10))});
      end
      seq.push_back({1'b0, pick_end()});
    end else if (kind < 65) begin
      nmw = ROM[$urandom_range(ROM_SIZE - 1)].nm;
      for (int i = 7; i >= 0; i--)
        if (nmw[8*i +: 8] != 0) seq.push_back({1'b0, nmw[8*i +: 8]});
      seq.push_back({1'b0, pick_end()});
    end else if (kind < 75) begin
      // The short names, in random case, against the terminators that matter to them.
      nmw = TOL_NAMES[$urandom_range(4)];
      for (int i = 7; i >= 0; i--)
        if (nmw[8*i +: 8] != 0) seq.push_back({1'b0, flip_case(nmw[8*i +: 8])});
      case ($urandom_range(3))
        0: seq.push_back({1'b0, CH_EQ});
        1: seq.push_back({1'b0, 8'h00});
        2: seq.push_back({1'b0, CH_SEMI});
        default: seq.push_back({1'b0, 8'($urandom_range(255))});
      endcase
    end else if (kind < 83) begin
      seq.push_back({1'b0, flip_case(8'("a" + $urandom_range(25)))});
      n = $urandom_range(13, 7);
      repeat (n) seq.push_back({1'b0, any_alnum()});
      seq.push_back({1'b0, pick_end()});
    end else if (kind < 90) begin
      case ($urandom_range(2))
        0: seq.push_back({1'b0, CH_SHARP});
        1: begin
          seq.push_back({1'b0, CH_SHARP});
          seq.push_back({1'b0, CH_LX});
        end
        default: ;
      endcase
      seq.push_back({1'b0, 8'($urandom_range(255))});
    end else begin
      // Noise: raw bytes with random begin flags, idle bytes and aborted attempts.
      n = $urandom_range(6, 1);
      repeat (n) seq.push_back({1'($urandom_range(3) == 0), 8'($urandom_range(255))});
    end
    if (!seq[0][8]) seq[0][8] = 1'b1;
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part.
    send_byte("q", 0);
    send_text("&lt;");
    send_text("&#65;");
    send_text("&#x1F600;");
    send_text("&#4294967297;");
    send_text("&#XfFfFfFfFf ");
    send_text("&amp ");
    send_text("&AMP=");
    send_text("&nbsp");
    send_byte(8'h00, 0);
    send_text("&Quot.");
    send_text("&foo;");
    send_text("&thetasym;");
    send_text("&thetasyms;");
    send_text("&#;");
    send_text("&#xg");
    send_text("&!");
    send_text("#12;");
    send_text("otimes;");
    send_byte(8'hFF, 1);
    send_text("&#12");
    send_text("&gt;");
    // A digit run long enough to saturate the consumed count.
    send_text("&#");
    repeat (300) send_byte("7", 0);
    send_byte(CH_SEMI, 0);
    drain();

    // Random part, over phases of different idle and stall rates; the sender waits for all results between them.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 12 : 0;
      stall_pct = (ph == 2) ? 45 : (ph == 3) ? 12 : 0;
      sent = 0;
      while (sent < PHASE_BYTES) send_random_ref();
      send_text(" ");
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;

    in_valid <= 0;
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: html_entity_decoder_core.f
design/hed_pkg.sv
design/hed_match.sv
design/html_entity_decoder_core.sv
design/hed_checker.sv
sim/tb_html_entity_decoder_core.sv
